// File: rtl/core/assert_macros.svh
// Assertion macros for the checker of the core.
// No dependencies; included by tdfdr_checker, which holds the concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tdfdr_pkg.sv
// Package of the target-decoy FDR threshold core: widths, codes, state and command types.
// No dependencies; used by every module of the core.
package tdfdr_pkg;

    localparam int STORE_DEPTH_DEF = 4096;

    localparam int SCORE_W     = 32;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int QV_W        = 17;
    localparam int CNT_OUT_W   = 13;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 80;
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = 4;

    localparam logic [QV_W-1:0]    Q_ONE     = 17'd65536;
    localparam logic [SCORE_W-1:0] MAX_SCORE = 32'h7FFF_FFFF;
    localparam logic [CFG_W-1:0]   PIT_RESET = 17'd65536;
    localparam logic [CFG_W-1:0]   FDR_RESET = 17'd655;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FDR = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] RS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] RS_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] RS_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] RS_ZERO = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 3'd0,
        FN_DECOY  = 3'd1,
        FN_TARGET = 3'd2,
        FN_THRESH = 3'd3,
        FN_QUERY  = 3'd4
    } func_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_APPEND,
        ST_CNT,
        ST_TH_INIT,
        ST_TH_CHK,
        ST_TH_RD,
        ST_TH_CAP,
        ST_TH_MUL,
        ST_TH_CMP,
        ST_NOFOUND,
        ST_CUT,
        ST_FIN_T,
        ST_S_INIT,
        ST_S_CHK,
        ST_S_ISSUE,
        ST_S_STEP,
        ST_S_DONE,
        ST_Q_T,
        ST_Q_MUL1,
        ST_Q_MUL2,
        ST_Q_CHK,
        ST_Q_ZERO,
        ST_Q_SAT,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_APPEND,
        DP_CNT,
        DP_TH_INIT,
        DP_NOFOUND,
        DP_T_READ,
        DP_T_CAP,
        DP_TH_MUL,
        DP_TH_CMP,
        DP_CUT,
        DP_S_INIT,
        DP_S_ISSUE,
        DP_S_STEP,
        DP_S_DONE,
        DP_Q_MUL1,
        DP_Q_MUL2,
        DP_Q_ZERO,
        DP_Q_SAT,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_END,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_tgt;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              srch_done;
        logic              hit;
        logic              a_last;
        logic              den_zero;
        logic              sat;
        logic              div_last;
    } dp_stat_t;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } cfg_wr_t;

endpackage

// File: rtl/core/tdfdr_ram.sv
// Simple dual-port score store: one write port, one registered read port.
// Depends on tdfdr_pkg for the score width.
module tdfdr_ram #(
    parameter int DEPTH = tdfdr_pkg::STORE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [tdfdr_pkg::SCORE_W-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic [tdfdr_pkg::SCORE_W-1:0] rdata
);

    logic [tdfdr_pkg::SCORE_W-1:0] mem [DEPTH];
    logic [tdfdr_pkg::SCORE_W-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tdfdr_datapath.sv
// Datapath of the FDR threshold core: score stores, binary search, products, divider.
// Depends on tdfdr_pkg and tdfdr_ram; driven by tdfdr_ctrl through dp_cmd_t.
module tdfdr_datapath #(
    parameter int STORE_DEPTH = tdfdr_pkg::STORE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tdfdr_pkg::dp_cmd_t                cmd,
    input  tdfdr_pkg::cfg_wr_t                cfg,
    input  logic [tdfdr_pkg::FUNC_W-1:0]      s_func,
    input  logic [tdfdr_pkg::SCORE_W-1:0]     s_score,
    output tdfdr_pkg::dp_stat_t               stat,
    output logic [tdfdr_pkg::STATUS_W-1:0]    m_status,
    output logic [tdfdr_pkg::M_TDATA_W-1:0]   m_data
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int KW = tdfdr_pkg::CFG_W + CW;
    localparam int PW = KW + CW;
    localparam int DW = 2 * CW;
    localparam int SW = tdfdr_pkg::SCORE_W;
    localparam int PAD_W = tdfdr_pkg::M_TDATA_W - SW - tdfdr_pkg::QV_W
                           - 2 * tdfdr_pkg::CNT_OUT_W;

    // Registers with reset.
    logic [tdfdr_pkg::CFG_W-1:0] pit_reg, fdr_reg;
    logic [CW-1:0]               nd_reg, nt_reg;

    // Working registers.
    logic [tdfdr_pkg::FUNC_W-1:0]   func_reg;
    logic [SW-1:0]                  key_reg;
    logic [SW-1:0]                  d_last_reg, t_last_reg;
    logic [CW-1:0]                  a_reg, lo_reg, hi_reg;
    logic [KW-1:0]                  k1_reg, k2_reg;
    logic [PW-1:0]                  lhs_reg, rhs_reg, num_reg, rem_reg;
    logic [DW-1:0]                  den_reg;
    logic [tdfdr_pkg::DIV_STEPS-1:0] div_q_reg;
    logic [tdfdr_pkg::DIV_CNT_W-1:0] div_i_reg;
    logic [tdfdr_pkg::STATUS_W-1:0] status_reg, m_status_reg;
    logic [SW-1:0]                  cutoff_reg;
    logic [tdfdr_pkg::QV_W-1:0]     qv_reg;
    logic [CW-1:0]                  da_reg, ta_reg;
    logic [tdfdr_pkg::M_TDATA_W-1:0] m_data_reg;

    // Combinational helpers.
    logic [CW-1:0] mid, n_sel, cnt_sel;
    logic [SW-1:0] last_sel, app_val, d_rdata, t_rdata, probe;
    logic          is_tgt, full, we_d, we_t;
    logic [AW-1:0] t_raddr;
    logic [PW-1:0] trial;

    // Store selection for appends and searches.
    always_comb begin
        is_tgt   = (func_reg == tdfdr_pkg::FN_TARGET);
        cnt_sel  = is_tgt ? nt_reg : nd_reg;
        last_sel = is_tgt ? t_last_reg : d_last_reg;
        full     = (cnt_sel == CW'(STORE_DEPTH));
        app_val  = ((cnt_sel != '0) && ($signed(last_sel) > $signed(key_reg))) ?
                   last_sel : key_reg;
        we_d     = (cmd.op == tdfdr_pkg::DP_APPEND) && !is_tgt && !full;
        we_t     = (cmd.op == tdfdr_pkg::DP_APPEND) && is_tgt && !full;
        n_sel    = cmd.sel_tgt ? nt_reg : nd_reg;
        mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
        t_raddr  = (cmd.op == tdfdr_pkg::DP_T_READ) ? a_reg[AW-1:0] : mid[AW-1:0];
        probe    = cmd.sel_tgt ? t_rdata : d_rdata;
        trial    = PW'(den_reg) << div_i_reg;
    end

    tdfdr_ram #(.DEPTH(STORE_DEPTH), .AW(AW)) u_decoy_ram (
        .aclk  (aclk),
        .we    (we_d),
        .waddr (cnt_sel[AW-1:0]),
        .wdata (app_val),
        .raddr (mid[AW-1:0]),
        .rdata (d_rdata)
    );

    tdfdr_ram #(.DEPTH(STORE_DEPTH), .AW(AW)) u_target_ram (
        .aclk  (aclk),
        .we    (we_t),
        .waddr (cnt_sel[AW-1:0]),
        .wdata (app_val),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // Configuration registers and store counts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pit_reg <= tdfdr_pkg::PIT_RESET;
            fdr_reg <= tdfdr_pkg::FDR_RESET;
            nd_reg  <= '0;
            nt_reg  <= '0;
        end else begin
            if (cfg.en && (cfg.idx == tdfdr_pkg::CFG_PIT)) begin
                pit_reg <= cfg.data;
            end
            if (cfg.en && (cfg.idx == tdfdr_pkg::CFG_FDR)) begin
                fdr_reg <= cfg.data;
            end
            if (cmd.op == tdfdr_pkg::DP_CLEAR) begin
                nd_reg <= '0;
                nt_reg <= '0;
            end
            if (we_d) begin
                nd_reg <= nd_reg + CW'(1);
            end
            if (we_t) begin
                nt_reg <= nt_reg + CW'(1);
            end
        end
    end

    // Working registers, stepped by the controller's command.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            tdfdr_pkg::DP_LOAD: begin
                func_reg   <= s_func;
                key_reg    <= s_score;
                status_reg <= tdfdr_pkg::RS_OK;
                cutoff_reg <= '0;
                qv_reg     <= '0;
                da_reg     <= '0;
                ta_reg     <= '0;
            end
            tdfdr_pkg::DP_APPEND: begin
                if (full) begin
                    status_reg <= tdfdr_pkg::RS_FULL;
                end else if (is_tgt) begin
                    t_last_reg <= app_val;
                end else begin
                    d_last_reg <= app_val;
                end
            end
            tdfdr_pkg::DP_CNT: begin
                da_reg <= nd_reg;
                ta_reg <= nt_reg;
            end
            tdfdr_pkg::DP_TH_INIT: begin
                k1_reg <= KW'(pit_reg) * KW'(nt_reg);
                k2_reg <= KW'(fdr_reg) * KW'(nd_reg);
                a_reg  <= '0;
            end
            tdfdr_pkg::DP_NOFOUND: begin
                cutoff_reg <= tdfdr_pkg::MAX_SCORE;
                status_reg <= ((nd_reg == '0) && (nt_reg != '0)) ?
                              tdfdr_pkg::RS_ZERO : tdfdr_pkg::RS_NONE;
            end
            tdfdr_pkg::DP_T_CAP: begin
                key_reg <= t_rdata;
            end
            tdfdr_pkg::DP_TH_MUL: begin
                lhs_reg <= PW'(k1_reg) * PW'(da_reg);
                rhs_reg <= PW'(k2_reg) * PW'(nt_reg - a_reg);
            end
            tdfdr_pkg::DP_TH_CMP: begin
                if (lhs_reg < rhs_reg) begin
                    cutoff_reg <= key_reg;
                end else begin
                    a_reg <= a_reg + CW'(1);
                end
            end
            tdfdr_pkg::DP_CUT: begin
                key_reg <= cutoff_reg;
            end
            tdfdr_pkg::DP_S_INIT: begin
                lo_reg <= '0;
                hi_reg <= n_sel;
            end
            tdfdr_pkg::DP_S_STEP: begin
                if ($signed(probe) < $signed(key_reg)) begin
                    lo_reg <= mid + CW'(1);
                end else begin
                    hi_reg <= mid;
                end
            end
            tdfdr_pkg::DP_S_DONE: begin
                if (cmd.sel_tgt) begin
                    ta_reg <= n_sel - lo_reg;
                end else begin
                    da_reg <= n_sel - lo_reg;
                end
            end
            tdfdr_pkg::DP_Q_MUL1: begin
                k1_reg  <= KW'(pit_reg) * KW'(nt_reg);
                den_reg <= DW'(nd_reg) * DW'(ta_reg);
            end
            tdfdr_pkg::DP_Q_MUL2: begin
                num_reg <= PW'(k1_reg) * PW'(da_reg);
            end
            tdfdr_pkg::DP_Q_ZERO: begin
                qv_reg     <= tdfdr_pkg::Q_ONE;
                status_reg <= tdfdr_pkg::RS_ZERO;
            end
            tdfdr_pkg::DP_Q_SAT: begin
                qv_reg <= tdfdr_pkg::Q_ONE;
            end
            tdfdr_pkg::DP_DIV_INIT: begin
                rem_reg   <= num_reg;
                div_q_reg <= '0;
                div_i_reg <= tdfdr_pkg::DIV_CNT_W'(tdfdr_pkg::DIV_STEPS - 1);
            end
            tdfdr_pkg::DP_DIV_STEP: begin
                // Restoring division, one quotient bit per cycle from the top.
                if (rem_reg >= trial) begin
                    rem_reg              <= rem_reg - trial;
                    div_q_reg[div_i_reg] <= 1'b1;
                end
                div_i_reg <= div_i_reg - tdfdr_pkg::DIV_CNT_W'(1);
            end
            tdfdr_pkg::DP_DIV_END: begin
                qv_reg <= tdfdr_pkg::QV_W'(div_q_reg);
            end
            tdfdr_pkg::DP_EMIT: begin
                m_status_reg <= status_reg;
                m_data_reg   <= {{PAD_W{1'b0}},
                                 tdfdr_pkg::CNT_OUT_W'(ta_reg),
                                 tdfdr_pkg::CNT_OUT_W'(da_reg),
                                 qv_reg, cutoff_reg};
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller.
    always_comb begin
        stat.func      = func_reg;
        stat.empty     = (nd_reg == '0) || (nt_reg == '0);
        stat.srch_done = (lo_reg >= hi_reg);
        stat.hit       = (lhs_reg < rhs_reg);
        stat.a_last    = ((a_reg + CW'(1)) == nt_reg);
        stat.den_zero  = (den_reg == '0);
        stat.sat       = (num_reg >= (PW'(den_reg) << tdfdr_pkg::DIV_STEPS));
        stat.div_last  = (div_i_reg == '0);
    end

    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;

endmodule

// File: rtl/core/tdfdr_ctrl.sv
// Controller of the FDR threshold core: sequences each transaction through the datapath.
// Depends on tdfdr_pkg for the state, command and status types.
module tdfdr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  tdfdr_pkg::dp_stat_t stat,
    output tdfdr_pkg::dp_cmd_t  cmd
);

    tdfdr_pkg::ctrl_state_t state_reg, state_next;
    tdfdr_pkg::ctrl_state_t ret_reg, ret_next;
    logic                   tgt_reg, tgt_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   emit;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdfdr_pkg::ST_IDLE;
            ret_reg     <= tdfdr_pkg::ST_IDLE;
            tgt_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            tgt_reg     <= tgt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign emit = (state_reg == tdfdr_pkg::ST_EMIT) && (!m_valid_reg || m_tready);

    // Next state; a search records its store and where to return.
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        tgt_next     = tgt_reg;
        m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        case (state_reg)
            tdfdr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tdfdr_pkg::ST_DECODE;
                end
            end
            tdfdr_pkg::ST_DECODE: begin
                case (tdfdr_pkg::func_t'(stat.func))
                    tdfdr_pkg::FN_CLEAR:  state_next = tdfdr_pkg::ST_CLEAR;
                    tdfdr_pkg::FN_DECOY:  state_next = tdfdr_pkg::ST_APPEND;
                    tdfdr_pkg::FN_TARGET: state_next = tdfdr_pkg::ST_APPEND;
                    tdfdr_pkg::FN_THRESH: state_next = tdfdr_pkg::ST_TH_INIT;
                    tdfdr_pkg::FN_QUERY: begin
                        tgt_next   = 1'b0;
                        ret_next   = tdfdr_pkg::ST_Q_T;
                        state_next = tdfdr_pkg::ST_S_INIT;
                    end
                    default: state_next = tdfdr_pkg::ST_EMIT;
                endcase
            end
            tdfdr_pkg::ST_CLEAR:   state_next = tdfdr_pkg::ST_CNT;
            tdfdr_pkg::ST_APPEND:  state_next = tdfdr_pkg::ST_CNT;
            tdfdr_pkg::ST_CNT:     state_next = tdfdr_pkg::ST_EMIT;
            tdfdr_pkg::ST_TH_INIT: state_next = tdfdr_pkg::ST_TH_CHK;
            tdfdr_pkg::ST_TH_CHK: begin
                state_next = stat.empty ? tdfdr_pkg::ST_NOFOUND : tdfdr_pkg::ST_TH_RD;
            end
            tdfdr_pkg::ST_TH_RD:   state_next = tdfdr_pkg::ST_TH_CAP;
            tdfdr_pkg::ST_TH_CAP: begin
                tgt_next   = 1'b0;
                ret_next   = tdfdr_pkg::ST_TH_MUL;
                state_next = tdfdr_pkg::ST_S_INIT;
            end
            tdfdr_pkg::ST_TH_MUL:  state_next = tdfdr_pkg::ST_TH_CMP;
            tdfdr_pkg::ST_TH_CMP: begin
                if (stat.hit) begin
                    state_next = tdfdr_pkg::ST_CUT;
                end else if (stat.a_last) begin
                    state_next = tdfdr_pkg::ST_NOFOUND;
                end else begin
                    state_next = tdfdr_pkg::ST_TH_RD;
                end
            end
            tdfdr_pkg::ST_NOFOUND: state_next = tdfdr_pkg::ST_CUT;
            tdfdr_pkg::ST_CUT: begin
                tgt_next   = 1'b0;
                ret_next   = tdfdr_pkg::ST_FIN_T;
                state_next = tdfdr_pkg::ST_S_INIT;
            end
            tdfdr_pkg::ST_FIN_T: begin
                tgt_next   = 1'b1;
                ret_next   = tdfdr_pkg::ST_EMIT;
                state_next = tdfdr_pkg::ST_S_INIT;
            end
            tdfdr_pkg::ST_S_INIT:  state_next = tdfdr_pkg::ST_S_CHK;
            tdfdr_pkg::ST_S_CHK: begin
                state_next = stat.srch_done ? tdfdr_pkg::ST_S_DONE : tdfdr_pkg::ST_S_ISSUE;
            end
            tdfdr_pkg::ST_S_ISSUE: state_next = tdfdr_pkg::ST_S_STEP;
            tdfdr_pkg::ST_S_STEP:  state_next = tdfdr_pkg::ST_S_CHK;
            tdfdr_pkg::ST_S_DONE:  state_next = ret_reg;
            tdfdr_pkg::ST_Q_T: begin
                tgt_next   = 1'b1;
                ret_next   = tdfdr_pkg::ST_Q_MUL1;
                state_next = tdfdr_pkg::ST_S_INIT;
            end
            tdfdr_pkg::ST_Q_MUL1:  state_next = tdfdr_pkg::ST_Q_MUL2;
            tdfdr_pkg::ST_Q_MUL2:  state_next = tdfdr_pkg::ST_Q_CHK;
            tdfdr_pkg::ST_Q_CHK: begin
                if (stat.den_zero) begin
                    state_next = tdfdr_pkg::ST_Q_ZERO;
                end else if (stat.sat) begin
                    state_next = tdfdr_pkg::ST_Q_SAT;
                end else begin
                    state_next = tdfdr_pkg::ST_DIV_INIT;
                end
            end
            tdfdr_pkg::ST_Q_ZERO:   state_next = tdfdr_pkg::ST_EMIT;
            tdfdr_pkg::ST_Q_SAT:    state_next = tdfdr_pkg::ST_EMIT;
            tdfdr_pkg::ST_DIV_INIT: state_next = tdfdr_pkg::ST_DIV_STEP;
            tdfdr_pkg::ST_DIV_STEP: begin
                if (stat.div_last) begin
                    state_next = tdfdr_pkg::ST_DIV_END;
                end
            end
            tdfdr_pkg::ST_DIV_END:  state_next = tdfdr_pkg::ST_EMIT;
            tdfdr_pkg::ST_EMIT: begin
                if (emit) begin
                    state_next = tdfdr_pkg::ST_IDLE;
                end
            end
            default: state_next = tdfdr_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd.op      = tdfdr_pkg::DP_NOP;
        cmd.sel_tgt = tgt_reg;
        case (state_reg)
            tdfdr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = tdfdr_pkg::DP_LOAD;
                end
            end
            tdfdr_pkg::ST_CLEAR:    cmd.op = tdfdr_pkg::DP_CLEAR;
            tdfdr_pkg::ST_APPEND:   cmd.op = tdfdr_pkg::DP_APPEND;
            tdfdr_pkg::ST_CNT:      cmd.op = tdfdr_pkg::DP_CNT;
            tdfdr_pkg::ST_TH_INIT:  cmd.op = tdfdr_pkg::DP_TH_INIT;
            tdfdr_pkg::ST_TH_RD:    cmd.op = tdfdr_pkg::DP_T_READ;
            tdfdr_pkg::ST_TH_CAP:   cmd.op = tdfdr_pkg::DP_T_CAP;
            tdfdr_pkg::ST_TH_MUL:   cmd.op = tdfdr_pkg::DP_TH_MUL;
            tdfdr_pkg::ST_TH_CMP:   cmd.op = tdfdr_pkg::DP_TH_CMP;
            tdfdr_pkg::ST_NOFOUND:  cmd.op = tdfdr_pkg::DP_NOFOUND;
            tdfdr_pkg::ST_CUT:      cmd.op = tdfdr_pkg::DP_CUT;
            tdfdr_pkg::ST_S_INIT:   cmd.op = tdfdr_pkg::DP_S_INIT;
            tdfdr_pkg::ST_S_ISSUE:  cmd.op = tdfdr_pkg::DP_S_ISSUE;
            tdfdr_pkg::ST_S_STEP:   cmd.op = tdfdr_pkg::DP_S_STEP;
            tdfdr_pkg::ST_S_DONE:   cmd.op = tdfdr_pkg::DP_S_DONE;
            tdfdr_pkg::ST_Q_MUL1:   cmd.op = tdfdr_pkg::DP_Q_MUL1;
            tdfdr_pkg::ST_Q_MUL2:   cmd.op = tdfdr_pkg::DP_Q_MUL2;
            tdfdr_pkg::ST_Q_ZERO:   cmd.op = tdfdr_pkg::DP_Q_ZERO;
            tdfdr_pkg::ST_Q_SAT:    cmd.op = tdfdr_pkg::DP_Q_SAT;
            tdfdr_pkg::ST_DIV_INIT: cmd.op = tdfdr_pkg::DP_DIV_INIT;
            tdfdr_pkg::ST_DIV_STEP: cmd.op = tdfdr_pkg::DP_DIV_STEP;
            tdfdr_pkg::ST_DIV_END:  cmd.op = tdfdr_pkg::DP_DIV_END;
            tdfdr_pkg::ST_EMIT: begin
                if (emit) begin
                    cmd.op = tdfdr_pkg::DP_EMIT;
                end
            end
            default: cmd.op = tdfdr_pkg::DP_NOP;
        endcase
    end

    assign s_tready = (state_reg == tdfdr_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// File: rtl/core/target_decoy_fdr_threshold_core.sv
// Channel   Dir  Ports                                  Content
// s_        in   s_tvalid s_tready s_tdata s_tuser      one command with its score
// m_        out  m_tvalid m_tready m_tdata m_tuser      one result per command
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data register writes
//
// One command is in work at a time. Clear and append pass through decode, the store
// step and the count capture. A threshold request runs one binary search in the decoy
// store per target it examines, through its single read port. A query takes two searches
// and a 16-bit restoring division, skipped on a zero divisor or a saturated quotient.
// The result waits in an output register, so a new command is taken while it stalls.
// Reset is synchronous active low; the stores are not cleared, the counts are.
module target_decoy_fdr_threshold_core #(
    parameter int STORE_DEPTH = tdfdr_pkg::STORE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tdfdr_pkg::S_TDATA_W-1:0]     s_tdata,   // score[31:0]
    input  logic [tdfdr_pkg::FUNC_W-1:0]        s_tuser,   // func[2:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cutoff_score[31:0], qvalue[48:32], decoys_above[61:49], targets_above[74:62], zero pad
    output logic [tdfdr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [tdfdr_pkg::STATUS_W-1:0]      m_tuser,   // status[1:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdfdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdfdr_pkg::CFG_W-1:0]         cfg_data
);

    tdfdr_pkg::dp_cmd_t  cmd;
    tdfdr_pkg::dp_stat_t stat;
    tdfdr_pkg::cfg_wr_t  cfg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    always_comb begin
        cfg.en   = cfg_valid;
        cfg.idx  = cfg_index;
        cfg.data = cfg_data;
    end

    tdfdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tdfdr_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_func   (s_tuser),
        .s_score  (s_tdata),
        .stat     (stat),
        .m_status (m_tuser),
        .m_data   (m_tdata)
    );

endmodule

// File: rtl/core/tdfdr_checker.sv
// Port-level checker of the FDR threshold core, bound to the top level.
// Depends on tdfdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tdfdr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tdfdr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [tdfdr_pkg::STATUS_W-1:0]  m_tuser
);

    // A stalled result holds.
    `TDF_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Only one command is in work: ready drops after an accepted transaction.
    `TDF_ASSERT_NXT(a_one, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second command taken while busy")

    // The q-value never exceeds one.
    `TDF_ASSERT_IMP(a_qmax, aclk, aresetn, m_tvalid, m_tdata[48:32] <= tdfdr_pkg::Q_ONE, "q-value above one")

    // No threshold found gives the maximum cutoff and no q-value.
    `TDF_ASSERT_IMP(a_none, aclk, aresetn, m_tvalid && (m_tuser == tdfdr_pkg::RS_NONE), (m_tdata[31:0] == tdfdr_pkg::MAX_SCORE) && (m_tdata[48:32] == '0), "bad no-threshold result")

    // A zero denominator saturates either the q-value or the cutoff.
    `TDF_ASSERT_IMP(a_zero, aclk, aresetn, m_tvalid && (m_tuser == tdfdr_pkg::RS_ZERO), (m_tdata[48:32] == tdfdr_pkg::Q_ONE) || (m_tdata[31:0] == tdfdr_pkg::MAX_SCORE), "zero denominator not saturated")

endmodule

bind target_decoy_fdr_threshold_core tdfdr_checker u_tdfdr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
